### hdl/bba_pkg.sv
`default_nettype none
package bba_pkg;

  // Region geometry
  localparam int TOP_ORDER   = 10;
  localparam int ORDER_COUNT = TOP_ORDER + 1;
  localparam int REGION_UNITS = 1 << TOP_ORDER;
  localparam int STORE_DEPTH = 2 << TOP_ORDER;
  localparam int K_W     = $clog2(ORDER_COUNT);
  localparam int OFF_W   = TOP_ORDER;
  localparam int STORE_W = TOP_ORDER + 1;
  localparam int DEPTH_W = TOP_ORDER + 1;
  localparam int CODE_W  = $clog2(ORDER_COUNT + 1);

  // Word field widths
  localparam int SIZE_W  = 16;
  localparam int ADDR_W  = 10;
  localparam int FSIZE_W = 11;
  localparam int STAT_W  = 2;
  localparam int WANT_W  = $clog2(SIZE_W + 1);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_BLOCK = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ADDR_W-1:0]  block_address;
    logic [FSIZE_W-1:0] freed_size;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_POP,
    ST_SPLIT,
    ST_GRANT,
    ST_FREE_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic search;
    logic pop;
    logic split;
    logic grant;
    logic fail_alloc;
    logic free_commit;
    logic free_fail;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic reject;
    logic split_more;
    logic no_block;
    logic clear_last;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

### hdl/bba_ctrl.sv
`default_nettype none
module bba_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  bba_pkg::dp_status_t stat,
  output bba_pkg::dp_cmd_t    cmd
);

  bba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bba_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_next = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_IDLE: begin
        if (req_valid) state_next = bba_pkg::ST_SEARCH;
      end
      bba_pkg::ST_SEARCH: begin
        // a latched free goes straight to the table check
        if (stat.is_free) state_next = bba_pkg::ST_FREE_CHK;
        else if (stat.reject) state_next = bba_pkg::ST_DONE;
        else state_next = bba_pkg::ST_POP;
      end
      bba_pkg::ST_POP:      state_next = bba_pkg::ST_SPLIT;
      bba_pkg::ST_SPLIT: begin
        if (!stat.split_more) state_next = bba_pkg::ST_GRANT;
      end
      bba_pkg::ST_GRANT:    state_next = bba_pkg::ST_DONE;
      bba_pkg::ST_FREE_CHK: state_next = bba_pkg::ST_DONE;
      bba_pkg::ST_DONE: begin
        if (!stat.out_busy) state_next = bba_pkg::ST_IDLE;
      end
      default: state_next = bba_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      bba_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      bba_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      bba_pkg::ST_SEARCH: begin
        if (!stat.is_free) begin
          if (stat.reject) cmd.fail_alloc = 1'b1;
          else cmd.search = 1'b1;
        end
      end
      bba_pkg::ST_POP:   cmd.pop = 1'b1;
      bba_pkg::ST_SPLIT: cmd.split = stat.split_more;
      bba_pkg::ST_GRANT: cmd.grant = 1'b1;
      bba_pkg::ST_FREE_CHK: begin
        if (stat.no_block) cmd.free_fail = 1'b1;
        else cmd.free_commit = 1'b1;
      end
      bba_pkg::ST_DONE: cmd.emit = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

### hdl/bba_datapath.sv
`default_nettype none
module bba_datapath (
  input  wire                 clk,
  input  wire                 rst,
  input  bba_pkg::req_t       req,
  input  bba_pkg::dp_cmd_t    cmd,
  output bba_pkg::dp_status_t stat,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output bba_pkg::rsp_t       rsp
);

  function automatic logic [bba_pkg::STORE_W-1:0] seg_base(
    input logic [bba_pkg::K_W-1:0] k
  );
    logic [bba_pkg::STORE_W:0] b;
    b = (bba_pkg::STORE_W+1)'(bba_pkg::STORE_DEPTH)
        - ((bba_pkg::STORE_W+1)'(2) << (bba_pkg::TOP_ORDER - int'(k)));
    return b[bba_pkg::STORE_W-1:0];
  endfunction

  function automatic logic [bba_pkg::DEPTH_W-1:0] seg_cap(
    input logic [bba_pkg::K_W-1:0] k
  );
    return bba_pkg::DEPTH_W'(1) << (bba_pkg::TOP_ORDER - int'(k));
  endfunction

  function automatic logic [bba_pkg::WANT_W-1:0] ceil_log2(
    input logic [bba_pkg::SIZE_W-1:0] s
  );
    logic [bba_pkg::SIZE_W-1:0] m;
    logic [bba_pkg::WANT_W-1:0] r;
    m = (s == '0) ? '0 : s - bba_pkg::SIZE_W'(1);
    r = '0;
    for (int i = 0; i < bba_pkg::SIZE_W; i++) begin
      if (m[i]) r = bba_pkg::WANT_W'(i + 1);
    end
    return r;
  endfunction

  // Memories
  logic [bba_pkg::OFF_W-1:0]  stack_mem [bba_pkg::STORE_DEPTH];
  logic [bba_pkg::CODE_W-1:0] code_mem  [bba_pkg::REGION_UNITS];

  logic [bba_pkg::DEPTH_W-1:0] depth [bba_pkg::ORDER_COUNT];

  logic                         is_free;
  logic                         too_big;
  logic [bba_pkg::K_W-1:0]      want;
  logic [bba_pkg::ADDR_W-1:0]   addr;
  logic [bba_pkg::K_W-1:0]      k;
  logic [bba_pkg::OFF_W-1:0]    pop_off;
  logic [bba_pkg::CODE_W-1:0]   code_rd;
  logic [bba_pkg::OFF_W-1:0]    clr_count;
  bba_pkg::rsp_t                res;

  logic [bba_pkg::WANT_W-1:0]   want_full;
  logic                         found;
  logic [bba_pkg::K_W-1:0]      found_k;
  logic [bba_pkg::K_W-1:0]      km1;
  logic [bba_pkg::K_W-1:0]      free_k;
  logic                         addr_out;

  logic                         push_en;
  logic [bba_pkg::K_W-1:0]      push_k;
  logic [bba_pkg::OFF_W-1:0]    push_val;
  logic                         push_ok;

  logic                         st_we;
  logic [bba_pkg::STORE_W-1:0]  st_waddr;
  logic [bba_pkg::OFF_W-1:0]    st_wdata;
  logic [bba_pkg::STORE_W-1:0]  st_raddr;

  logic                         ct_we;
  logic [bba_pkg::OFF_W-1:0]    ct_waddr;
  logic [bba_pkg::CODE_W-1:0]   ct_wdata;

  assign want_full = ceil_log2(req.request_size);

  // Lowest non-empty order at or above the wanted one
  always_comb begin
    found   = 1'b0;
    found_k = '0;
    for (int i = bba_pkg::ORDER_COUNT - 1; i >= 0; i--) begin
      if (depth[i] != '0 && bba_pkg::K_W'(i) >= want) begin
        found   = 1'b1;
        found_k = bba_pkg::K_W'(i);
      end
    end
  end

  assign km1      = k - bba_pkg::K_W'(1);
  assign free_k   = bba_pkg::K_W'(code_rd - bba_pkg::CODE_W'(1));
  assign addr_out = 32'(addr) >= bba_pkg::REGION_UNITS;

  assign stat.is_free    = is_free;
  assign stat.reject     = too_big || !found;
  assign stat.split_more = k > want;
  assign stat.no_block   = addr_out || code_rd == '0
                           || 32'(code_rd) > bba_pkg::ORDER_COUNT;
  assign stat.clear_last = clr_count == '1;
  assign stat.out_busy   = rsp_valid && rsp_stall;

  // Push path shared by split and free
  always_comb begin
    push_en  = cmd.split || cmd.free_commit;
    push_k   = cmd.split ? km1 : free_k;
    push_val = cmd.split ? pop_off + (bba_pkg::OFF_W'(1) << km1)
                         : addr[bba_pkg::OFF_W-1:0];
    push_ok  = depth[push_k] < seg_cap(push_k);
  end

  always_comb begin
    st_we    = 1'b0;
    st_waddr = seg_base(push_k) + bba_pkg::STORE_W'(depth[push_k]);
    st_wdata = push_val;
    if (cmd.clear_step) begin
      // seed the top order's single entry with offset zero
      st_we    = 1'b1;
      st_waddr = seg_base(bba_pkg::K_W'(bba_pkg::TOP_ORDER));
      st_wdata = '0;
    end else if (push_en && push_ok) begin
      st_we = 1'b1;
    end
    st_raddr = seg_base(k) + bba_pkg::STORE_W'(depth[k])
               - bba_pkg::STORE_W'(1);
  end

  always_comb begin
    ct_we    = cmd.clear_step || cmd.grant || cmd.free_commit;
    ct_waddr = addr[bba_pkg::OFF_W-1:0];
    ct_wdata = '0;
    if (cmd.clear_step) begin
      ct_waddr = clr_count;
    end else if (cmd.grant) begin
      ct_waddr = pop_off;
      ct_wdata = bba_pkg::CODE_W'(want) + bba_pkg::CODE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) stack_mem[st_waddr] <= st_wdata;
    if (cmd.pop) pop_off <= stack_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (ct_we) code_mem[ct_waddr] <= ct_wdata;
    if (cmd.load) code_rd <= code_mem[req.address[bba_pkg::OFF_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bba_pkg::ORDER_COUNT; i++) begin
        depth[i] <= (i == bba_pkg::TOP_ORDER) ? bba_pkg::DEPTH_W'(1) : '0;
      end
      clr_count <= '0;
    end else begin
      if (cmd.clear_step) clr_count <= clr_count + bba_pkg::OFF_W'(1);
      if (cmd.pop) depth[k] <= depth[k] - bba_pkg::DEPTH_W'(1);
      if (push_en && push_ok) depth[push_k] <= depth[push_k] + bba_pkg::DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_free <= req.kind == bba_pkg::KIND_FREE;
      too_big <= 32'(want_full) > bba_pkg::TOP_ORDER;
      want    <= bba_pkg::K_W'(want_full);
      addr    <= req.address;
    end
    if (cmd.search) k <= found_k;
    if (cmd.split) k <= km1;
  end

  always_ff @(posedge clk) begin
    if (cmd.fail_alloc) begin
      res.status        <= bba_pkg::STAT_NO_SPACE;
      res.block_address <= '0;
      res.freed_size    <= '0;
    end
    if (cmd.grant) begin
      res.status        <= bba_pkg::STAT_OK;
      res.block_address <= bba_pkg::ADDR_W'(pop_off);
      res.freed_size    <= '0;
    end
    if (cmd.free_commit) begin
      res.status        <= bba_pkg::STAT_OK;
      res.block_address <= addr;
      res.freed_size    <= bba_pkg::FSIZE_W'(1) << free_k;
    end
    if (cmd.free_fail) begin
      res.status        <= bba_pkg::STAT_NO_BLOCK;
      res.block_address <= addr;
      res.freed_size    <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) rsp <= res;
  end

endmodule
`default_nettype wire

### hdl/buddy_block_allocator.sv
`default_nettype none
// Power-of-two buddy allocator over a region of 1024 units. Each order keeps
// a LIFO stack of free block offsets; an allocate word rounds its size up to
// a power of two, pops the smallest fitting order and splits the block down
// one level per cycle, pushing each upper half. A free word returns the
// recorded size and pushes the offset back (buddies are never merged).
// After reset the block clears all 1024 size-table entries, one entry a
// cycle, with req_stall high. One item is worked at a time: a free passes
// the search, table-check and done states, a refused allocate search and
// done, and a granted allocate search, pop, split (one level per step, up
// to 10), grant and done before the result word is registered. The stack
// memory has one push port; the stack read on pop and the size-table read
// are registered. req_stall drops in the same cycle as the result turns
// valid. A new request is taken while the last result still waits in the
// output register; its own result then holds until that one is taken.
module buddy_block_allocator (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_stall,
  input  bba_pkg::req_t  req,
  output logic           rsp_valid,
  input  wire            rsp_stall,
  output bba_pkg::rsp_t  rsp
);

  // Commands down, status up
  bba_pkg::dp_cmd_t    cmd;
  bba_pkg::dp_status_t stat;

  // Sequence clear, search, pop, split, grant and free steps
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the free stacks, depth counters, size table and output register
  bba_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
